FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

FILE: src/mpmc_pkg.sv
// ----------------------------------------------------------------------------
// mpmc_pkg
// Types and constants shared by the pattern match counter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mpmc_pkg;

    localparam int NUM_PATTERNS = 6;
    localparam int MAX_LEN      = 8;
    localparam int TOTAL_WIDTH  = 24;

    localparam int CHAR_W       = 8;
    localparam int PATTERN_W    = 64;
    localparam int LEN_W        = 4;
    localparam int LENGTHS_W    = 24;
    localparam int HITS_W       = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    localparam int HIST_W       = CHAR_W * (MAX_LEN - 1);
    localparam int WIN_W        = CHAR_W * MAX_LEN;
    localparam int FILL_W       = $clog2(MAX_LEN);

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LAST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTHS   = 3'd6;

    typedef logic [TOTAL_WIDTH-1:0] t_total;

    // One classified byte travelling from front to back
    typedef struct packed {
        logic [HITS_W-1:0] hits;
        logic              line_end;
    } t_hit_item;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

FILE: src/mpmc_front.sv
// ----------------------------------------------------------------------------
// mpmc_front
// Pattern registers, line history and parallel pattern compare.
// ----------------------------------------------------------------------------
`default_nettype none

module mpmc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mpmc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mpmc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_accept,
    input  logic [mpmc_pkg::CHAR_W-1:0]         i_in_char,
    input  logic                                i_line_end,
    output mpmc_pkg::t_hit_item                 o_item
);
    import mpmc_pkg::*;

    logic [PATTERN_W-1:0]    r_pattern [NUM_PATTERNS];
    logic [LENGTHS_W-1:0]    r_lengths;
    logic [HIST_W-1:0]       r_history;
    logic [FILL_W-1:0]       r_fill;

    logic [WIN_W-1:0]        w_window;
    logic [NUM_PATTERNS-1:0] w_hit;
    logic [HITS_W-1:0]       w_count;

    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_LEN - 1);

    assign w_window = {r_history, i_in_char};

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PATTERNS; k++) begin
                r_pattern[k] <= '0;
            end
            r_lengths <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index inside {[CFG_PAT_FIRST:CFG_PAT_LAST]}) begin
                if (int'(i_cfg_index) < NUM_PATTERNS) begin
                    r_pattern[i_cfg_index] <= i_cfg_data;
                end
            end else if (i_cfg_index == CFG_LENGTHS) begin
                r_lengths <= i_cfg_data[LENGTHS_W-1:0];
            end
        end
    end

    // Per pattern: try every possible length, keep the one configured.
    always_comb begin
        logic [LEN_W-1:0] len;
        logic             ok;
        w_hit = '0;
        for (int k = 0; k < NUM_PATTERNS; k++) begin
            len = r_lengths[LEN_W*k +: LEN_W];
            for (int l = 1; l <= MAX_LEN; l++) begin
                ok = 1'b1;
                for (int i = 0; i < l; i++) begin
                    if (r_pattern[k][CHAR_W*i +: CHAR_W] !=
                        w_window[CHAR_W*(l-1-i) +: CHAR_W]) begin
                        ok = 1'b0;
                    end
                end
                if (len == LEN_W'(l) && {1'b0, r_fill} >= (FILL_W+1)'(l - 1)) begin
                    w_hit[k] = ok;
                end
            end
        end
    end

    always_comb begin
        w_count = '0;
        for (int k = 0; k < NUM_PATTERNS; k++) begin
            w_count = w_count + HITS_W'(w_hit[k]);
        end
    end

    assign o_item.hits     = w_count;
    assign o_item.line_end = i_line_end;

    // History shifts on every accepted byte, clears at line end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history <= '0;
            r_fill    <= '0;
        end else if (i_accept) begin
            if (i_line_end) begin
                r_history <= '0;
                r_fill    <= '0;
            end else begin
                r_history <= w_window[HIST_W-1:0];
                if (r_fill != FILL_MAX) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/mpmc_queue.sv
// ----------------------------------------------------------------------------
// mpmc_queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mpmc_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  mpmc_pkg::t_hit_item         i_item,
    input  logic                        i_pop,
    output mpmc_pkg::t_hit_item         o_item,
    output mpmc_pkg::t_queue_status     o_status
);
    import mpmc_pkg::*;

    t_hit_item           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0] LAST_PTR  = QPTR_W'(QUEUE_DEPTH - 1);

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == DEPTH_CNT);
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_push_when_full, i_clk, i_rst_n, i_push && r_count == DEPTH_CNT)
    `ASSERT_NEVER(a_pop_when_empty, i_clk, i_rst_n, i_pop && r_count == '0)
    `ASSERT_CLK(a_count_tracks, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count != '0))

endmodule

`default_nettype wire

FILE: src/mpmc_back.sv
// ----------------------------------------------------------------------------
// mpmc_back
// Saturating line total and registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mpmc_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mpmc_pkg::t_queue_status         i_q_status,
    input  mpmc_pkg::t_hit_item             i_q_item,
    output logic                            o_pop,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [mpmc_pkg::HITS_W-1:0]     o_matches_here,
    output logic [mpmc_pkg::TOTAL_WIDTH-1:0] o_running_total,
    output logic                            o_total_saturated,
    output logic                            o_line_done
);
    import mpmc_pkg::*;

    localparam t_total TOTAL_MAX = {TOTAL_WIDTH{1'b1}};

    t_total                  r_total;
    logic                    r_valid;
    logic [HITS_W-1:0]       r_hits;
    t_total                  r_out_total;
    logic                    r_sat;
    logic                    r_last;

    logic [TOTAL_WIDTH:0]    w_sum;
    logic                    w_sat;
    t_total                  w_new_total;

    assign o_pop       = !i_q_status.empty && (!r_valid || !i_stall);
    assign w_sum       = {1'b0, r_total} + (TOTAL_WIDTH+1)'(i_q_item.hits);
    assign w_sat       = (w_sum >= {1'b0, TOTAL_MAX});
    assign w_new_total = w_sat ? TOTAL_MAX : w_sum[TOTAL_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_total <= i_q_item.line_end ? '0 : w_new_total;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hits      <= i_q_item.hits;
            r_out_total <= w_new_total;
            r_sat       <= w_sat;
            r_last      <= i_q_item.line_end;
        end
    end

    assign o_valid           = r_valid;
    assign o_matches_here    = r_hits;
    assign o_running_total   = r_out_total;
    assign o_total_saturated = r_sat;
    assign o_line_done       = r_last;

    `ASSERT_CLK(a_sat_means_max, i_clk, i_rst_n, (r_valid && r_sat) |-> (r_out_total == TOTAL_MAX))
    `ASSERT_CLK(a_line_clears, i_clk, i_rst_n, (o_pop && i_q_item.line_end) |=> (r_total == '0))

endmodule

`default_nettype wire

FILE: src/multi_pattern_match_counter.sv
// ----------------------------------------------------------------------------
// multi_pattern_match_counter
// Counts overlapping occurrences of up to six byte patterns per text line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) takes one text byte and its end-of-line
//   flag per transaction. Output channel (o_valid / i_stall) returns one result
//   per byte: matches ending at that byte, the saturating line total, the
//   saturation flag and a copy of the end-of-line flag.
//   Config channel (i_cfg_valid / o_cfg_ready) writes pattern_0..5 at index
//   0..5 and the packed lengths at index 6; other indexes are dropped. Ready
//   is always high. Write only while no byte is in flight.
//   A byte goes through the queue and the result register to the output.
//   Throughput: one byte per cycle while the queue is not full; all patterns
//   are compared against the byte history in the front stage in the accepting
//   cycle, and the back stage does one saturating add per unstalled cycle.
//   Reset clears patterns, lengths, history and total; no results pending.
//   When the receiver stalls the result register holds; the two-entry queue
//   absorbs further bytes and o_stall rises once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_match_counter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // byte input
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [mpmc_pkg::CHAR_W-1:0]         i_in_char,
    input  logic                                i_line_end,
    // result output
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [mpmc_pkg::HITS_W-1:0]         o_matches_here,
    output logic [mpmc_pkg::TOTAL_WIDTH-1:0]    o_running_total,
    output logic                                o_total_saturated,
    output logic                                o_line_done,
    // config writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mpmc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mpmc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mpmc_pkg::*;

    logic          w_accept;
    logic          w_pop;
    t_hit_item     w_front_item;
    t_hit_item     w_q_item;
    t_queue_status w_q_status;

    // Front stalls only when the queue is full
    assign o_stall     = w_q_status.full;
    assign w_accept    = i_valid && !w_q_status.full;
    assign o_cfg_ready = 1'b1;

    mpmc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_in_char   (i_in_char),
        .i_line_end  (i_line_end),
        .o_item      (w_front_item)
    );

    mpmc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_accept),
        .i_item   (w_front_item),
        .i_pop    (w_pop),
        .o_item   (w_q_item),
        .o_status (w_q_status)
    );

    mpmc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_status        (w_q_status),
        .i_q_item          (w_q_item),
        .o_pop             (w_pop),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_matches_here    (o_matches_here),
        .o_running_total   (o_running_total),
        .o_total_saturated (o_total_saturated),
        .o_line_done       (o_line_done)
    );

endmodule

`default_nettype wire
